/* src/rgba_pixel_store_bilinear_sampler_macros.svh */
// Assertion macros shared by the sampler RTL
`ifndef RGBA_PIXEL_STORE_BILINEAR_SAMPLER_MACROS_SVH
`define RGBA_PIXEL_STORE_BILINEAR_SAMPLER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define RGBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define RGBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RGBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RGBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/rgbs_pkg.sv */
// Types, constants and helpers for the RGBA pixel store and bilinear sampler
`default_nettype none
package rgbs_pkg;

	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 256;
	localparam int FRAC_BITS = 8;

	localparam int CFG_W      = 8;
	localparam int COORD_IN_W = 12;
	localparam int IN_FRAC_W  = 8;
	localparam int PIX_W      = 8;
	localparam int WORD_W     = 32;
	localparam int CH_N       = 4;

	localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int ROW_W       = 2 * CFG_W + 1;
	localparam int IDX_W       = (ROW_W + 1 > ADDR_W + 1) ? ROW_W + 1 : ADDR_W + 1;

	// blend widths: lane input, weight, lane output
	localparam int LW    = PIX_W + FRAC_BITS;
	localparam int WT_W  = FRAC_BITS + 1;
	localparam int LO_W  = LW + FRAC_BITS;
	localparam logic [WT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// request codes
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	// byte order codes
	localparam logic ORDER_BGRA = 1'b0;
	localparam logic ORDER_RGBA = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_COLUMN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW    = 1'b1;

	// lane positions
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	typedef struct packed {
		logic [1:0]                   req_type;
		logic signed [COORD_IN_W-1:0] x_int;
		logic signed [COORD_IN_W-1:0] y_int;
		logic [IN_FRAC_W-1:0]         x_frac;
		logic [IN_FRAC_W-1:0]         y_frac;
		logic                         struct_order;
		logic [PIX_W-1:0]             in_red;
		logic [PIX_W-1:0]             in_green;
		logic [PIX_W-1:0]             in_blue;
		logic [PIX_W-1:0]             in_alpha;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_alpha;
		logic             write_done;
	} rsp_t;

	typedef logic [LW-1:0]   lane_t;
	typedef lane_t [CH_N-1:0] lanes_t;
	typedef logic [LO_W-1:0] wlane_t;
	typedef wlane_t [CH_N-1:0] wlanes_t;

	// 1/256 fraction rescaled to FRAC_BITS
	function automatic logic [FRAC_BITS-1:0] scale_frac(input logic [IN_FRAC_W-1:0] f);
		logic [FRAC_BITS+IN_FRAC_W-1:0] t;
		t = {f, {FRAC_BITS{1'b0}}};
		return t[IN_FRAC_W +: FRAC_BITS];
	endfunction

endpackage
`default_nettype wire

/* src/rgbs_ram.sv */
// Generic single-port RAM with registered read
`default_nettype none
module rgbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* src/rgbs_lerp.sv */
// Four-lane linear blend a*(ONE-f) + b*f, shared by all blend passes
`default_nettype none
module rgbs_lerp import rgbs_pkg::*; (
	input  wire lanes_t                 a,
	input  wire lanes_t                 b,
	input  wire logic [FRAC_BITS-1:0]   f,
	output wlanes_t                     y
);

	logic [WT_W-1:0] wt_hi;
	logic [WT_W-1:0] wt_lo;

	assign wt_hi = {1'b0, f};
	assign wt_lo = ONE - wt_hi;

	for (genvar i = 0; i < CH_N; i++) begin : g_lane
		logic [LO_W:0] pa;
		logic [LO_W:0] pb;
		logic [LO_W:0] sum;
		assign pa  = (LO_W+1)'(a[i]) * (LO_W+1)'(wt_lo);
		assign pb  = (LO_W+1)'(b[i]) * (LO_W+1)'(wt_hi);
		assign sum = pa + pb;
		assign y[i] = sum[LO_W-1:0];
	end

endmodule
`default_nettype wire

/* src/rgba_pixel_store_bilinear_sampler.sv */
// Top level: RGBA pixel store with pixel write, clamped read and bilinear sampling.
// Busy drops in the same cycle that the result strobe rises, so a new request can be
// accepted while the strobe is high. A sample makes four reads of the single-port image RAM
// plus three passes through the shared blend unit. Results are strobed for one cycle;
// the receiver cannot stall.
// arst_n clears the sequencer and sets last_column/last_row to 255; image RAM is not cleared.
`default_nettype none
`include "rgba_pixel_store_bilinear_sampler_macros.svh"
module rgba_pixel_store_bilinear_sampler import rgbs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request channel
	input  wire logic                 start,
	output logic                      busy,
	input  wire req_t                 req,
	// result strobe
	output logic                      done,
	output rsp_t                      rsp,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// sequencer states
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CLAMP = 9'b000000010,  // clamp coordinates, pick fractions
		S_MUL0  = 9'b000000100,  // row base of top row, neighbor coords
		S_MUL1  = 9'b000001000,  // row base of lower row
		S_MEM   = 9'b000010000,  // one RAM access per cycle, k selects the pixel
		S_LAST  = 9'b000100000,  // last read data arrives
		S_TOP   = 9'b001000000,  // blend top pair along x
		S_BOT   = 9'b010000000,  // blend bottom pair along x
		S_FIN   = 9'b100000000   // blend rows along y
	} state_t;

	state_t state_q, state_d;

	logic [CFG_W-1:0] last_column_q;
	logic [CFG_W-1:0] last_row_q;

	req_t             req_q;
	logic [CFG_W-1:0] cx_q, cy_q, nx_q, ny_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q;
	logic             wr_ok_q;
	logic [ROW_W-1:0] row0_q, row1_q;
	logic [1:0]       k_q;
	logic             rd_oob_q;
	logic [WORD_W-1:0] pix_q [CH_N];
	lanes_t           top_q, bot_q;
	rsp_t             rsp_q;
	logic             done_q;

	// config regs always take a transfer; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_column_q <= '1;
			last_row_q    <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LAST_COLUMN: last_column_q <= cfg_data;
				CFG_LAST_ROW:    last_row_q    <= cfg_data;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Coordinate clamping, evaluated from the latched request
	// ---------------------------------------------------------------
	logic [COORD_IN_W-1:0] xu, yu, lc_ext, lr_ext, lim_x_ext, lim_y_ext;
	logic [CFG_W-1:0]      lim_x, lim_y;
	logic                  x_neg, y_neg;
	logic [CFG_W-1:0]      cl_cx, cl_cy;
	logic [FRAC_BITS-1:0]  cl_fx, cl_fy;
	logic                  cl_wr_ok;

	assign xu     = req_q.x_int;
	assign yu     = req_q.y_int;
	assign x_neg  = xu[COORD_IN_W-1];
	assign y_neg  = yu[COORD_IN_W-1];
	assign lc_ext = {{(COORD_IN_W-CFG_W){1'b0}}, last_column_q};
	assign lr_ext = {{(COORD_IN_W-CFG_W){1'b0}}, last_row_q};
	// bilinear limit is one short of the edge, floored at zero
	assign lim_x  = (last_column_q != '0) ? last_column_q - 1'b1 : '0;
	assign lim_y  = (last_row_q != '0) ? last_row_q - 1'b1 : '0;
	assign lim_x_ext = {{(COORD_IN_W-CFG_W){1'b0}}, lim_x};
	assign lim_y_ext = {{(COORD_IN_W-CFG_W){1'b0}}, lim_y};

	always_comb begin
		cl_cx    = xu[CFG_W-1:0];
		cl_cy    = yu[CFG_W-1:0];
		cl_fx    = '0;
		cl_fy    = '0;
		cl_wr_ok = !x_neg && !y_neg && (xu <= lc_ext) && (yu <= lr_ext);
		case (req_q.req_type)
			REQ_READ: begin
				if (x_neg)            cl_cx = '0;
				else if (xu > lc_ext) cl_cx = last_column_q;
				if (y_neg)            cl_cy = '0;
				else if (yu > lr_ext) cl_cy = last_row_q;
			end
			REQ_SAMPLE: begin
				if (x_neg)                 cl_cx = '0;
				else if (xu >= lim_x_ext)  cl_cx = lim_x;
				else                       cl_fx = scale_frac(req_q.x_frac);
				if (y_neg)                 cl_cy = '0;
				else if (yu >= lim_y_ext)  cl_cy = lim_y;
				else                       cl_fy = scale_frac(req_q.y_frac);
			end
			default: ;
		endcase
	end

	// right/lower neighbor, saturated at the edge
	logic [CFG_W:0] cx_inc, cy_inc;
	assign cx_inc = {1'b0, cx_q} + 1'b1;
	assign cy_inc = {1'b0, cy_q} + 1'b1;

	// ---------------------------------------------------------------
	// Shared row multiplier: row * (last_column + 1)
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] mul_row;
	logic [CFG_W:0]   width_px;
	logic [ROW_W-1:0] mul_prod;

	assign width_px = {1'b0, last_column_q} + 1'b1;
	assign mul_row  = (state_q == S_MUL1) ? ny_q : cy_q;
	assign mul_prod = ROW_W'(mul_row) * ROW_W'(width_px);

	// ---------------------------------------------------------------
	// Image RAM access
	// ---------------------------------------------------------------
	logic [IDX_W-1:0]  idx;
	logic              idx_oob;
	logic              ram_we;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] rd_word;
	logic              is_write, is_read, is_sample;

	assign is_write  = (req_q.req_type == REQ_WRITE);
	assign is_read   = (req_q.req_type == REQ_READ);
	assign is_sample = (req_q.req_type == REQ_SAMPLE);

	assign idx = IDX_W'(k_q[1] ? row1_q : row0_q) + IDX_W'(k_q[0] ? nx_q : cx_q);
	assign idx_oob = (idx >= IDX_W'(STORE_DEPTH));
	assign ram_we  = (state_q == S_MEM) && is_write && wr_ok_q && !idx_oob;

	assign ram_wdata = (req_q.struct_order == ORDER_RGBA)
		? {req_q.in_alpha, req_q.in_blue, req_q.in_green, req_q.in_red}
		: {req_q.in_alpha, req_q.in_red, req_q.in_green, req_q.in_blue};

	rgbs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STORE_DEPTH)
	) u_image_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (idx[ADDR_W-1:0]),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// an index past the store reads as zero
	assign rd_word = rd_oob_q ? '0 : ram_rdata;

	// ---------------------------------------------------------------
	// Shared blend unit, fed per pass
	// ---------------------------------------------------------------
	lanes_t               lerp_a, lerp_b;
	logic [FRAC_BITS-1:0] lerp_f;
	wlanes_t              lerp_y;

	function automatic lanes_t word_lanes(input logic [WORD_W-1:0] w);
		lanes_t l;
		l[CH_RED]   = LW'(w[16 +: PIX_W]);
		l[CH_GREEN] = LW'(w[8  +: PIX_W]);
		l[CH_BLUE]  = LW'(w[0  +: PIX_W]);
		l[CH_ALPHA] = LW'(w[24 +: PIX_W]);
		return l;
	endfunction

	always_comb begin
		lerp_a = word_lanes(pix_q[0]);
		lerp_b = word_lanes(pix_q[1]);
		lerp_f = fx_q;
		if (state_q == S_BOT) begin
			lerp_a = word_lanes(pix_q[2]);
			lerp_b = word_lanes(pix_q[3]);
		end else if (state_q == S_FIN) begin
			lerp_a = top_q;
			lerp_b = bot_q;
			lerp_f = fy_q;
		end
	end

	rgbs_lerp u_lerp (
		.a (lerp_a),
		.b (lerp_b),
		.f (lerp_f),
		.y (lerp_y)
	);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	logic accept;
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_CLAMP;
			S_CLAMP: state_d = S_MUL0;
			S_MUL0:  state_d = S_MUL1;
			S_MUL1:  state_d = S_MEM;
			S_MEM: begin
				if (is_sample) begin
					if (k_q == 2'd3) state_d = S_LAST;
				end else if (is_read) begin
					state_d = S_LAST;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LAST:  state_d = is_sample ? S_TOP : S_IDLE;
			S_TOP:   state_d = S_BOT;
			S_BOT:   state_d = S_FIN;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			// result strobe: last cycle of a request leaves for idle
			done_q  <= (state_q != S_IDLE) && (state_d == S_IDLE);
			if (state_q == S_MUL1) k_q <= '0;
			else if (state_q == S_MEM) k_q <= k_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_oob_q <= idx_oob;
		if (accept) req_q <= req;
		if (state_q == S_CLAMP) begin
			cx_q    <= cl_cx;
			cy_q    <= cl_cy;
			fx_q    <= cl_fx;
			fy_q    <= cl_fy;
			wr_ok_q <= cl_wr_ok;
		end
		if (state_q == S_MUL0) begin
			row0_q <= mul_prod;
			nx_q   <= (cx_inc > {1'b0, last_column_q}) ? last_column_q : cx_inc[CFG_W-1:0];
			ny_q   <= (cy_inc > {1'b0, last_row_q}) ? last_row_q : cy_inc[CFG_W-1:0];
		end
		if (state_q == S_MUL1) row1_q <= mul_prod;
		// read data arrives in the cycle after its address
		if (state_q == S_MEM && k_q != 2'd0) pix_q[k_q - 2'd1] <= rd_word;
		if (state_q == S_LAST) pix_q[3] <= rd_word;
		if (state_q == S_TOP) begin
			for (int i = 0; i < CH_N; i++) top_q[i] <= lerp_y[i][LW-1:0];
		end
		if (state_q == S_BOT) begin
			for (int i = 0; i < CH_N; i++) bot_q[i] <= lerp_y[i][LW-1:0];
		end
		// result word
		if (state_q == S_MEM && !is_sample && !is_read) begin
			rsp_q.out_red    <= '0;
			rsp_q.out_green  <= '0;
			rsp_q.out_blue   <= '0;
			rsp_q.out_alpha  <= '0;
			rsp_q.write_done <= ram_we;
		end
		if (state_q == S_LAST && is_read) begin
			rsp_q.out_red    <= (req_q.struct_order == ORDER_RGBA) ? rd_word[7:0] : rd_word[23:16];
			rsp_q.out_green  <= rd_word[15:8];
			rsp_q.out_blue   <= (req_q.struct_order == ORDER_RGBA) ? rd_word[23:16] : rd_word[7:0];
			rsp_q.out_alpha  <= rd_word[31:24];
			rsp_q.write_done <= 1'b0;
		end
		if (state_q == S_FIN) begin
			rsp_q.out_red    <= lerp_y[CH_RED][2*FRAC_BITS +: PIX_W];
			rsp_q.out_green  <= lerp_y[CH_GREEN][2*FRAC_BITS +: PIX_W];
			rsp_q.out_blue   <= lerp_y[CH_BLUE][2*FRAC_BITS +: PIX_W];
			rsp_q.out_alpha  <= lerp_y[CH_ALPHA][2*FRAC_BITS +: PIX_W];
			rsp_q.write_done <= 1'b0;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`RGBS_ASSERT_IMP(a_done_when_idle, clk, arst_n, done_q, !busy, "result strobe while busy")
	`RGBS_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy && !done_q, "accepted request did not start")
	`RGBS_ASSERT_NXT(a_write_reported, clk, arst_n, ram_we, done_q && rsp_q.write_done, "RAM write not reported")
	`RGBS_ASSERT_IMP(a_we_bounds, clk, arst_n, ram_we, wr_ok_q && is_write, "RAM write outside bounds")

endmodule
`default_nettype wire
